>>> src/tbt_pkg.sv
// shared types and defaults for the three-beacon trilateration unit
package tbt_pkg;

    localparam int COORD_WIDTH_DEF = 24;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_COLLINEAR = 2'd1,
        ST_FLAT      = 2'd2
    } t_status;

endpackage

>>> src/tbt_mul.sv
// two-stage signed multiplier, operand a split in two halves
module tbt_mul #(
    parameter int AW = 50,
    parameter int BW = 25
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [AW-1:0]     i_a,
    input  logic signed [BW-1:0]     i_b,
    output logic signed [AW+BW-1:0]  o_p
);
    localparam int LW = AW / 2;
    localparam int HW = AW - LW;
    localparam int PW = AW + BW;

    logic signed [LW:0]      w_a_lo;
    logic signed [HW-1:0]    w_a_hi;
    logic signed [LW+BW:0]   r_plo;
    logic signed [HW+BW-1:0] r_phi;
    logic signed [PW-1:0]    r_p;

    assign w_a_lo = $signed({1'b0, i_a[LW-1:0]});
    assign w_a_hi = i_a[AW-1:LW];

    // partial products, then the recombining add
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_plo <= w_a_lo * i_b;
            r_phi <= w_a_hi * i_b;
            r_p   <= (PW'(r_phi) <<< LW) + PW'(r_plo);
        end
    end

    assign o_p = r_p;

endmodule

>>> src/tbt_div.sv
// pipelined signed divider, round half away from zero, saturating quotient
module tbt_div #(
    parameter int NW  = 76,
    parameter int DNW = 52,
    parameter int QW  = 24,
    parameter int SBW = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic signed [NW-1:0]  i_num,
    input  logic signed [DNW-1:0] i_den,
    input  logic [SBW-1:0]        i_sb,
    output logic                  o_valid,
    output logic signed [QW-1:0]  o_q,
    output logic [SBW-1:0]        o_sb
);
    localparam int RW = (((NW + 2) > (DNW + 1 + QW)) ? (NW + 2) : (DNW + 1 + QW)) + 1;
    localparam logic [QW-1:0] LIM_POS = {1'b0, {(QW-1){1'b1}}};
    localparam logic [QW-1:0] LIM_NEG = {1'b1, {(QW-1){1'b0}}};

    // stage a: magnitudes
    logic              r_a_v;
    logic [NW-1:0]     r_a_n;
    logic [DNW-1:0]    r_a_d;
    logic              r_a_neg;
    logic [SBW-1:0]    r_a_sb;
    // stage b: rounding offset folded in, 2n+d over 2d
    logic              r_b_v;
    logic [RW-1:0]     r_b_rem;
    logic [DNW:0]      r_b_den;
    logic              r_b_neg;
    logic [SBW-1:0]    r_b_sb;
    // stage c and one stage per quotient bit
    logic              r_s_v   [QW+1];
    logic [RW-1:0]     r_s_rem [QW+1];
    logic [DNW:0]      r_s_den [QW+1];
    logic [QW-1:0]     r_s_q   [QW+1];
    logic              r_s_neg [QW+1];
    logic              r_s_ovf [QW+1];
    logic [SBW-1:0]    r_s_sb  [QW+1];
    // output stage
    logic              r_o_v;
    logic [QW-1:0]     r_o_q;
    logic [SBW-1:0]    r_o_sb;
    logic [QW-1:0]     n_o_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v    <= 1'b0;
            r_b_v    <= 1'b0;
            r_s_v[0] <= 1'b0;
            r_o_v    <= 1'b0;
        end else if (i_en) begin
            r_a_v    <= i_valid;
            r_b_v    <= r_a_v;
            r_s_v[0] <= r_b_v;
            r_o_v    <= r_s_v[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_n      <= i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
            r_a_d      <= i_den[DNW-1] ? DNW'(-i_den) : DNW'(i_den);
            r_a_neg    <= i_num[NW-1] ^ i_den[DNW-1];
            r_a_sb     <= i_sb;
            r_b_rem    <= RW'({r_a_n, 1'b0}) + RW'(r_a_d);
            r_b_den    <= {r_a_d, 1'b0};
            r_b_neg    <= r_a_neg;
            r_b_sb     <= r_a_sb;
            r_s_rem[0] <= r_b_rem;
            r_s_den[0] <= r_b_den;
            r_s_q[0]   <= '0;
            r_s_neg[0] <= r_b_neg;
            r_s_ovf[0] <= r_b_rem >= (RW'(r_b_den) << QW);
            r_s_sb[0]  <= r_b_sb;
            r_o_q      <= n_o_q;
            r_o_sb     <= r_s_sb[QW];
        end
    end

    // restoring steps, msb of the quotient first
    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [RW-1:0] w_sh;
        logic          w_ge;

        assign w_sh = RW'(r_s_den[k]) << (QW - 1 - k);
        assign w_ge = r_s_rem[k] >= w_sh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_s_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_s_v[k+1] <= r_s_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_s_rem[k+1] <= w_ge ? (r_s_rem[k] - w_sh) : r_s_rem[k];
                r_s_den[k+1] <= r_s_den[k];
                r_s_q[k+1]   <= {r_s_q[k][QW-2:0], w_ge};
                r_s_neg[k+1] <= r_s_neg[k];
                r_s_ovf[k+1] <= r_s_ovf[k];
                r_s_sb[k+1]  <= r_s_sb[k];
            end
        end
    end

    // sign and clamp
    always_comb begin
        if (r_s_neg[QW]) begin
            n_o_q = (r_s_ovf[QW] || (r_s_q[QW] > LIM_NEG)) ? LIM_NEG : QW'(-r_s_q[QW]);
        end else begin
            n_o_q = (r_s_ovf[QW] || r_s_q[QW][QW-1]) ? LIM_POS : r_s_q[QW];
        end
    end

    assign o_valid = r_o_v;
    assign o_q     = $signed(r_o_q);
    assign o_sb    = r_o_sb;

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s_v[QW] && !r_s_ovf[QW]) |-> (r_s_rem[QW] < RW'(r_s_den[QW])))
        else $error("divider remainder not reduced below divisor");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> ($stable(o_valid) && (!o_valid || $stable(o_q))))
        else $error("divider output moved during stall");

endmodule

>>> src/three_beacon_trilateration_unit.sv
// top level of the three-beacon 2-d trilateration pipeline
//
//  channel   | dir | handshake                           | payload
//  ----------+-----+-------------------------------------+------------------------------
//  s_axis    | in  | i_s_axis_tvalid / o_s_axis_tready   | three beacons x, y, range
//  m_axis    | out | o_m_axis_tvalid / i_m_axis_tready   | pos_x, pos_y, status
//
// one item enters per cycle while o_s_axis_tready is high; the pipeline depth is
// dominated by the two divider chains, each one quotient bit per stage
// reset is synchronous and active low; it clears only the valid bits
// the whole pipeline shares one enable; a two-entry output register keeps
// taking transfers while a result waits, and the pipeline halts only when both
// entries are full, losing and repeating nothing
module three_beacon_trilateration_unit #(
    parameter int COORD_WIDTH = tbt_pkg::COORD_WIDTH_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_s_axis_tvalid,
    output logic                                          o_s_axis_tready,
    // beacon0_x, beacon0_y, beacon0_range, beacon1_x, beacon1_y, beacon1_range,
    // beacon2_x, beacon2_y, beacon2_range, zero pad
    input  logic [(((9*COORD_WIDTH-3)+7)/8)*8-1:0]        i_s_axis_tdata,
    output logic                                          o_m_axis_tvalid,
    input  logic                                          i_m_axis_tready,
    // pos_x, pos_y, status, zero pad
    output logic [(((2*COORD_WIDTH+2)+7)/8)*8-1:0]        o_m_axis_tdata
);
    import tbt_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int DW    = CW + 1;          // coordinate differences
    localparam int WW    = 2 * CW + 2;      // w and z
    localparam int DDW   = 2 * DW + 1;      // determinant
    localparam int PYW   = 2 * DW;          // dy10*dy21
    localparam int NUMW  = WW + DW + 1;     // x numerator
    localparam int EW    = WW + 1;          // e1, e2
    localparam int YNW   = EW + DW + 1;     // y numerator
    localparam int OUT_W = (((2 * CW + 2) + 7) / 8) * 8;
    localparam int OX0 = 0;
    localparam int OY0 = CW;
    localparam int OR0 = 2 * CW;
    localparam int OX1 = 3 * CW - 1;
    localparam int OY1 = 4 * CW - 1;
    localparam int OR1 = 5 * CW - 1;
    localparam int OX2 = 6 * CW - 2;
    localparam int OY2 = 7 * CW - 2;
    localparam int OR2 = 8 * CW - 2;

    // what rides alongside the x divider
    typedef struct packed {
        logic signed [WW-1:0]  w;
        logic signed [WW-1:0]  z;
        logic signed [DW-1:0]  dx10;
        logic signed [DW-1:0]  dx21;
        logic signed [DW-1:0]  dy10;
        logic signed [DW-1:0]  dy21;
        logic signed [PYW-1:0] pyy;
        t_status               st;
    } t_xsb;

    // what rides alongside the y multipliers
    typedef struct packed {
        logic signed [CW-1:0]  px;
        logic signed [PYW-1:0] pyy;
        t_status               st;
    } t_ysb;

    // what rides alongside the y divider
    typedef struct packed {
        logic signed [CW-1:0]  px;
        t_status               st;
    } t_osb;

    // field unpack
    logic signed [CW-1:0] w_x0, w_y0, w_x1, w_y1, w_x2, w_y2;
    logic [CW-2:0]        w_r0, w_r1, w_r2;
    assign w_x0 = i_s_axis_tdata[OX0 +: CW];
    assign w_y0 = i_s_axis_tdata[OY0 +: CW];
    assign w_r0 = i_s_axis_tdata[OR0 +: CW-1];
    assign w_x1 = i_s_axis_tdata[OX1 +: CW];
    assign w_y1 = i_s_axis_tdata[OY1 +: CW];
    assign w_r1 = i_s_axis_tdata[OR1 +: CW-1];
    assign w_x2 = i_s_axis_tdata[OX2 +: CW];
    assign w_y2 = i_s_axis_tdata[OY2 +: CW];
    assign w_r2 = i_s_axis_tdata[OR2 +: CW-1];

    // valid bits of the stages outside the submodules
    logic r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r7_v, r8_v, r9_v, r10_v;

    // stage 1: squares and differences
    logic signed [2*CW-1:0] r1_x0s, r1_y0s, r1_x1s, r1_y1s, r1_x2s, r1_y2s;
    logic [2*CW-3:0]        r1_r0s, r1_r1s, r1_r2s;
    logic signed [DW-1:0]   r1_dx10, r1_dx21, r1_dy10, r1_dy21;
    // stage 2: w, z and the cross products
    logic signed [WW-1:0]   r2_w, r2_z;
    logic signed [PYW-1:0]  r2_p1, r2_p2, r2_pyy;
    logic signed [DW-1:0]   r2_dx10, r2_dx21, r2_dy10, r2_dy21;
    // stages 3 to 5: determinant and x numerator
    logic signed [DDW:0]    r3_d2, r4_d2, r5_d2;
    t_xsb                   r3_sb, r4_sb, r5_sb;
    logic signed [NUMW-1:0] r5_num;
    logic signed [WW+DW-1:0] m_wd, m_zd;
    // x divider
    logic                   d1_v;
    logic signed [CW-1:0]   d1_q;
    logic [$bits(t_xsb)-1:0] d1_sb;
    t_xsb                   d1_sbs;
    // stages 6 to 10: back substitution and y numerator
    logic signed [CW+DW-1:0] r6_pa, r6_pb;
    t_xsb                   r6_sb;
    logic signed [CW-1:0]   r6_px;
    logic signed [EW-1:0]   r7_e1, r7_e2;
    logic signed [DW-1:0]   r7_dy10, r7_dy21;
    t_ysb                   r7_sb, r8_sb, r9_sb;
    logic signed [EW+DW-1:0] m_e1, m_e2;
    logic signed [YNW-1:0]  r10_num;
    logic signed [PYW+1:0]  r10_den;
    t_osb                   r10_sb;
    // y divider
    logic                   d2_v;
    logic signed [CW-1:0]   d2_q;
    logic [$bits(t_osb)-1:0] d2_sb;
    t_osb                   d2_sbs;
    // output side
    logic [OUT_W-1:0]       w_res;
    logic                   r_main_v, r_skid_v;
    logic [OUT_W-1:0]       r_main_d, r_skid_d;

    logic en;
    assign en = !r_skid_v;
    assign o_s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v  <= 1'b0;
            r2_v  <= 1'b0;
            r3_v  <= 1'b0;
            r4_v  <= 1'b0;
            r5_v  <= 1'b0;
            r6_v  <= 1'b0;
            r7_v  <= 1'b0;
            r8_v  <= 1'b0;
            r9_v  <= 1'b0;
            r10_v <= 1'b0;
        end else if (en) begin
            r1_v  <= i_s_axis_tvalid;
            r2_v  <= r1_v;
            r3_v  <= r2_v;
            r4_v  <= r3_v;
            r5_v  <= r4_v;
            r6_v  <= d1_v;
            r7_v  <= r6_v;
            r8_v  <= r7_v;
            r9_v  <= r8_v;
            r10_v <= r9_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // stage 1
            r1_x0s  <= w_x0 * w_x0;
            r1_y0s  <= w_y0 * w_y0;
            r1_x1s  <= w_x1 * w_x1;
            r1_y1s  <= w_y1 * w_y1;
            r1_x2s  <= w_x2 * w_x2;
            r1_y2s  <= w_y2 * w_y2;
            r1_r0s  <= w_r0 * w_r0;
            r1_r1s  <= w_r1 * w_r1;
            r1_r2s  <= w_r2 * w_r2;
            r1_dx10 <= DW'(w_x1) - DW'(w_x0);
            r1_dx21 <= DW'(w_x2) - DW'(w_x1);
            r1_dy10 <= DW'(w_y1) - DW'(w_y0);
            r1_dy21 <= DW'(w_y2) - DW'(w_y1);
            // stage 2: differences of the squared circle equations
            r2_w <= $signed(WW'(r1_r0s)) - $signed(WW'(r1_r1s)) - WW'(r1_x0s)
                  - WW'(r1_y0s) + WW'(r1_x1s) + WW'(r1_y1s);
            r2_z <= $signed(WW'(r1_r1s)) - $signed(WW'(r1_r2s)) - WW'(r1_x1s)
                  - WW'(r1_y1s) + WW'(r1_x2s) + WW'(r1_y2s);
            r2_p1   <= r1_dx10 * r1_dy21;
            r2_p2   <= r1_dx21 * r1_dy10;
            r2_pyy  <= r1_dy10 * r1_dy21;
            r2_dx10 <= r1_dx10;
            r2_dx21 <= r1_dx21;
            r2_dy10 <= r1_dy10;
            r2_dy21 <= r1_dy21;
            // stage 3: determinant and status, multiplies start alongside
            r3_d2       <= (DDW+1)'(DDW'(r2_p1) - DDW'(r2_p2)) <<< 1;
            r3_sb.w     <= r2_w;
            r3_sb.z     <= r2_z;
            r3_sb.dx10  <= r2_dx10;
            r3_sb.dx21  <= r2_dx21;
            r3_sb.dy10  <= r2_dy10;
            r3_sb.dy21  <= r2_dy21;
            r3_sb.pyy   <= r2_pyy;
            if (r2_p1 == r2_p2) begin
                r3_sb.st <= ST_COLLINEAR;
            end else if (r2_dy10 == '0 || r2_dy21 == '0) begin
                r3_sb.st <= ST_FLAT;
            end else begin
                r3_sb.st <= ST_OK;
            end
            // stage 4: waits on the split multiplies
            r4_d2  <= r3_d2;
            r4_sb  <= r3_sb;
            // stage 5: x numerator w*dy21 - z*dy10
            r5_num <= NUMW'(m_wd) - NUMW'(m_zd);
            r5_d2  <= r4_d2;
            r5_sb  <= r4_sb;
            // stage 6: saturated x times the x differences
            r6_px  <= d1_q;
            r6_pa  <= d1_q * d1_sbs.dx10;
            r6_pb  <= d1_q * d1_sbs.dx21;
            r6_sb  <= d1_sbs;
            // stage 7: residuals of the two pair equations
            r7_e1     <= EW'(r6_sb.w) - (EW'(r6_pa) <<< 1);
            r7_e2     <= EW'(r6_sb.z) - (EW'(r6_pb) <<< 1);
            r7_dy10   <= r6_sb.dy10;
            r7_dy21   <= r6_sb.dy21;
            r7_sb.px  <= r6_px;
            r7_sb.pyy <= r6_sb.pyy;
            r7_sb.st  <= r6_sb.st;
            // stages 8 and 9: split multiplies
            r8_sb     <= r7_sb;
            r9_sb     <= r8_sb;
            // stage 10: mean of both y estimates over a common denominator
            r10_num   <= YNW'(m_e1) + YNW'(m_e2);
            r10_den   <= (PYW+2)'(r9_sb.pyy) <<< 2;
            r10_sb.px <= r9_sb.px;
            r10_sb.st <= r9_sb.st;
        end
    end

    tbt_mul #(.AW(WW), .BW(DW)) u_mul_wd (
        .i_clk (i_clk), .i_en (en), .i_a (r2_w), .i_b (r2_dy21), .o_p (m_wd)
    );

    tbt_mul #(.AW(WW), .BW(DW)) u_mul_zd (
        .i_clk (i_clk), .i_en (en), .i_a (r2_z), .i_b (r2_dy10), .o_p (m_zd)
    );

    tbt_div #(.NW(NUMW), .DNW(DDW+1), .QW(CW), .SBW($bits(t_xsb))) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r5_v),
        .i_num   (r5_num),
        .i_den   (r5_d2),
        .i_sb    (r5_sb),
        .o_valid (d1_v),
        .o_q     (d1_q),
        .o_sb    (d1_sb)
    );
    assign d1_sbs = t_xsb'(d1_sb);

    tbt_mul #(.AW(EW), .BW(DW)) u_mul_e1 (
        .i_clk (i_clk), .i_en (en), .i_a (r7_e1), .i_b (r7_dy21), .o_p (m_e1)
    );

    tbt_mul #(.AW(EW), .BW(DW)) u_mul_e2 (
        .i_clk (i_clk), .i_en (en), .i_a (r7_e2), .i_b (r7_dy10), .o_p (m_e2)
    );

    tbt_div #(.NW(YNW), .DNW(PYW+2), .QW(CW), .SBW($bits(t_osb))) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r10_v),
        .i_num   (r10_num),
        .i_den   (r10_den),
        .i_sb    (r10_sb),
        .o_valid (d2_v),
        .o_q     (d2_q),
        .o_sb    (d2_sb)
    );
    assign d2_sbs = t_osb'(d2_sb);

    // degenerate geometry forces the position to zero
    always_comb begin
        if (d2_sbs.st == ST_OK) begin
            w_res = OUT_W'({d2_sbs.st, d2_q, d2_sbs.px});
        end else begin
            w_res = OUT_W'({d2_sbs.st, {(2*CW){1'b0}}});
        end
    end

    // output register plus skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (i_m_axis_tready) begin
                r_skid_v <= 1'b0;
            end
        end else if (d2_v) begin
            if (!r_main_v || i_m_axis_tready) begin
                r_main_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (i_m_axis_tready) begin
            r_main_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (i_m_axis_tready) begin
                r_main_d <= r_skid_d;
            end
        end else if (d2_v) begin
            if (!r_main_v || i_m_axis_tready) begin
                r_main_d <= w_res;
            end else begin
                r_skid_d <= w_res;
            end
        end
    end

    assign o_m_axis_tvalid = r_main_v;
    assign o_m_axis_tdata  = r_main_d;

    a_skid_needs_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_main_v)
        else $error("skid entry holds data while output register is empty");

    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_main_v && !i_m_axis_tready))
        else $error("skid entry filled without a stalled output");

    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata[2*CW +: 2] != ST_OK))
        |-> (o_m_axis_tdata[2*CW-1:0] == '0))
        else $error("nonzero position reported with degenerate status");

endmodule
